// ----- hdl/e2q_pkg.sv -----
// e2q_pkg: types, constants and the arctangent table of the Euler to
// quaternion block. No dependencies.
package e2q_pkg;

    localparam int ANGLE_BITS    = 16;
    localparam int OUT_FRAC_BITS = 15;
    localparam int OUT_W         = OUT_FRAC_BITS + 1;
    localparam int CW            = 32;
    localparam int ZW            = 34;
    localparam int PW            = 2 * CW;
    localparam int SW            = PW + 1;

    localparam logic signed [CW-1:0] CORDIC_GAIN = 32'sh26DD3B6A;

    typedef struct packed {
        logic signed [15:0] yaw_angle;
        logic signed [15:0] pitch_angle;
        logic signed [15:0] roll_angle;
    } angles_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] quat_w;
        logic signed [OUT_W-1:0] quat_x;
        logic signed [OUT_W-1:0] quat_y;
        logic signed [OUT_W-1:0] quat_z;
    } quat_t;

    // half angles: 0 yaw, 1 pitch, 2 roll; 2^31 = 180 degrees
    typedef struct packed {
        logic            zero;
        logic [2:0][31:0] half;
    } front_item_t;

    typedef struct packed {
        logic [1:0] count;
        logic       push;
        logic       pop;
    } queue_stat_t;

    function automatic logic [31:0] atan_q31(input int i);
        logic [31:0] r;
        case (i)
            0: r = 32'h20000000;   1: r = 32'h12E4051E;   2: r = 32'h09FB385B;
            3: r = 32'h051111D4;   4: r = 32'h028B0D43;   5: r = 32'h0145D7E1;
            6: r = 32'h00A2F61E;   7: r = 32'h00517C55;   8: r = 32'h0028BE53;
            9: r = 32'h00145F2F;  10: r = 32'h000A2F98;  11: r = 32'h000517CC;
            12: r = 32'h00028BE6; 13: r = 32'h000145F3;  14: r = 32'h0000A2FA;
            15: r = 32'h0000517D; 16: r = 32'h000028BE;  17: r = 32'h0000145F;
            18: r = 32'h00000A30; 19: r = 32'h00000518;  20: r = 32'h0000028C;
            21: r = 32'h00000146; 22: r = 32'h000000A3;  23: r = 32'h00000051;
            24: r = 32'h00000029; 25: r = 32'h00000014;  26: r = 32'h0000000A;
            27: r = 32'h00000005; 28: r = 32'h00000003;  29: r = 32'h00000001;
            30: r = 32'h00000001;
            default: r = 32'h00000000;
        endcase
        return r;
    endfunction

endpackage

// ----- hdl/euler_to_quaternion.sv -----
// euler_to_quaternion: Z-Y-X Euler angles to unit quaternion, top level.
// Depends on e2q_pkg, e2q_front, e2q_queue, e2q_back.
//
// Usage:
//   Input channel s_valid/s_ready/s_data carries one request of yaw, pitch
//   and roll binary angles (32768 = 180 degrees). Result channel
//   m_valid/m_ready/m_data returns (w, x, y, z) in signed Q1.15.
//   Throughput: one request per cycle while the output is not stalled.
//   With no stalls a request passes, after the accepting edge, through the
//   queue, CORDIC input register, CORDIC_STEPS rotation stages, pair
//   products, triple products, sums and output register before m_valid rises.
//   A two-entry queue separates the front register from the back pipeline.
//   When m_valid is high and m_ready is low the back pipeline holds; the queue and front
//   register absorb up to three more requests before s_ready drops.
//   Reset (aresetn low, synchronous) empties all stages; outputs then show
//   m_valid low.
module euler_to_quaternion import e2q_pkg::*; #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  angles_t s_data,
    output logic    m_valid,
    input  logic    m_ready,
    output quat_t   m_data
);

    logic        f_valid, f_ready, b_valid, b_ready;
    front_item_t f_item, b_item;
    queue_stat_t q_stat;

    e2q_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .f_valid(f_valid), .f_ready(f_ready), .f_item(f_item)
    );

    e2q_queue u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(f_valid), .in_ready(f_ready), .in_item(f_item),
        .out_valid(b_valid), .out_ready(b_ready), .out_item(b_item),
        .stat(q_stat)
    );

    e2q_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(b_valid), .in_ready(b_ready), .in_item(b_item),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        q_stat.count != 2'd3) else $error("queue count out of range");
    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_stat.push && q_stat.count == 2'd2)) else $error("push into full queue");
    a_count_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_stat.push && !q_stat.pop) |=> q_stat.count == $past(q_stat.count) + 2'd1)
        else $error("queue count mismatch");
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && q_stat.count == 2'd0) else $error("not idle after reset");
`endif

endmodule

// ----- hdl/e2q_front.sv -----
// e2q_front: accepts angle requests, halves the angles and flags the
// all-zero case. Depends on e2q_pkg.
module e2q_front import e2q_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  angles_t     s_data,
    output logic        f_valid,
    input  logic        f_ready,
    output front_item_t f_item
);

    logic        valid_reg, valid_next;
    front_item_t item_reg;
    front_item_t item_next;
    logic [2:0][15:0] raw;

    function automatic logic [31:0] halve(input logic [15:0] a);
        logic [31:0] phase;
        phase = 32'(a[ANGLE_BITS-1:0]) << (32 - ANGLE_BITS);
        return 32'($signed(phase) >>> 1);
    endfunction

    assign raw[0] = s_data.yaw_angle;
    assign raw[1] = s_data.pitch_angle;
    assign raw[2] = s_data.roll_angle;

    assign s_ready = !valid_reg || f_ready;
    assign f_valid = valid_reg;
    assign f_item  = item_reg;

    always_comb begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (s_ready) begin
            valid_next = s_valid;
            item_next.zero = (raw[0][ANGLE_BITS-1:0] == '0) &&
                             (raw[1][ANGLE_BITS-1:0] == '0) &&
                             (raw[2][ANGLE_BITS-1:0] == '0);
            for (int k = 0; k < 3; k++) begin
                item_next.half[k] = halve(raw[k]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        item_reg <= item_next;
    end

endmodule

// ----- hdl/e2q_queue.sv -----
// e2q_queue: two-entry queue between front and back.
// Depends on e2q_pkg.
module e2q_queue import e2q_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  front_item_t in_item,
    output logic        out_valid,
    input  logic        out_ready,
    output front_item_t out_item,
    output queue_stat_t stat
);

    front_item_t mem_reg [2];
    logic        wr_reg, wr_next, rd_reg, rd_next;
    logic [1:0]  count_reg, count_next;
    logic        push, pop;

    assign in_ready  = count_reg != 2'd2;
    assign out_valid = count_reg != 2'd0;
    assign out_item  = mem_reg[rd_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign stat      = '{count: count_reg, push: push, pop: pop};

    always_comb begin
        wr_next    = wr_reg ^ push;
        rd_next    = rd_reg ^ pop;
        count_next = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg    <= 1'b0;
            rd_reg    <= 1'b0;
            count_reg <= 2'd0;
        end else begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
        if (push) begin
            mem_reg[wr_reg] <= in_item;
        end
    end

endmodule

// ----- hdl/e2q_back.sv -----
// e2q_back: pipelined CORDIC sine/cosine, quaternion products, rounding
// and saturation, output register. Depends on e2q_pkg.
module e2q_back import e2q_pkg::*; #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  front_item_t in_item,
    output logic        m_valid,
    input  logic        m_ready,
    output quat_t       m_data
);

    localparam int N = CORDIC_STEPS;

    logic adv;

    logic                 cv_reg [0:N];
    logic                 cz_reg [0:N];
    logic signed [CW-1:0] x_reg  [0:N][3];
    logic signed [CW-1:0] y_reg  [0:N][3];
    logic signed [ZW-1:0] a_reg  [0:N][3];

    logic                 p1v_reg, p1z_reg;
    logic signed [CW-1:0] c1c2_reg, s1s2_reg, c1s2_reg, s1c2_reg, c3_reg, s3_reg;
    logic                 p2v_reg, p2z_reg;
    logic signed [PW-1:0] t_reg [8];
    logic                 sv_reg, sz_reg;
    logic signed [SW-1:0] sum_reg [4];
    logic                 ov_reg;
    quat_t                o_reg;

    assign adv      = !ov_reg || m_ready;
    assign in_ready = adv;
    assign m_valid  = ov_reg;
    assign m_data   = o_reg;

    function automatic logic signed [CW-1:0] mul_q30(input logic signed [CW-1:0] a,
                                                     input logic signed [CW-1:0] b);
        logic signed [PW-1:0] p;
        p = a * b;
        p = p + (PW'(1) <<< 29);
        return CW'(p >>> 30);
    endfunction

    function automatic logic signed [OUT_W-1:0] to_out(input logic signed [SW-1:0] v);
        logic [SW-1:0] mag;
        logic [SW-1:0] t;
        logic signed [OUT_W-1:0] r;
        mag = v[SW-1] ? SW'(-v) : SW'(v);
        t   = mag >> (60 - OUT_FRAC_BITS);
        if (v[SW-1]) begin
            if (t > (SW'(1) << OUT_FRAC_BITS)) r = {1'b1, {(OUT_W-1){1'b0}}};
            else r = OUT_W'(-t);
        end else begin
            if (t > ((SW'(1) << OUT_FRAC_BITS) - SW'(1))) r = {1'b0, {(OUT_W-1){1'b1}}};
            else r = OUT_W'(t);
        end
        return r;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cv_reg[0] <= 1'b0;
        end else if (adv) begin
            cv_reg[0] <= in_valid;
        end
        if (adv) begin
            cz_reg[0] <= in_item.zero;
            for (int k = 0; k < 3; k++) begin
                x_reg[0][k] <= CORDIC_GAIN;
                y_reg[0][k] <= '0;
                a_reg[0][k] <= ZW'($signed(in_item.half[k]));
            end
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_step
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                cv_reg[i+1] <= 1'b0;
            end else if (adv) begin
                cv_reg[i+1] <= cv_reg[i];
            end
            if (adv) begin
                cz_reg[i+1] <= cz_reg[i];
                for (int k = 0; k < 3; k++) begin
                    if (!a_reg[i][k][ZW-1]) begin
                        x_reg[i+1][k] <= x_reg[i][k] - (y_reg[i][k] >>> i);
                        y_reg[i+1][k] <= y_reg[i][k] + (x_reg[i][k] >>> i);
                        a_reg[i+1][k] <= a_reg[i][k] - ZW'(atan_q31(i));
                    end else begin
                        x_reg[i+1][k] <= x_reg[i][k] + (y_reg[i][k] >>> i);
                        y_reg[i+1][k] <= y_reg[i][k] - (x_reg[i][k] >>> i);
                        a_reg[i+1][k] <= a_reg[i][k] + ZW'(atan_q31(i));
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1v_reg <= 1'b0;
            p2v_reg <= 1'b0;
            sv_reg  <= 1'b0;
            ov_reg  <= 1'b0;
        end else if (adv) begin
            p1v_reg <= cv_reg[N];
            p2v_reg <= p1v_reg;
            sv_reg  <= p2v_reg;
            ov_reg  <= sv_reg;
        end
        if (adv) begin
            p1z_reg  <= cz_reg[N];
            c1c2_reg <= mul_q30(x_reg[N][0], x_reg[N][1]);
            s1s2_reg <= mul_q30(y_reg[N][0], y_reg[N][1]);
            c1s2_reg <= mul_q30(x_reg[N][0], y_reg[N][1]);
            s1c2_reg <= mul_q30(y_reg[N][0], x_reg[N][1]);
            c3_reg   <= x_reg[N][2];
            s3_reg   <= y_reg[N][2];

            p2z_reg  <= p1z_reg;
            t_reg[0] <= c1c2_reg * c3_reg;
            t_reg[1] <= s1s2_reg * s3_reg;
            t_reg[2] <= c1c2_reg * s3_reg;
            t_reg[3] <= s1s2_reg * c3_reg;
            t_reg[4] <= c1s2_reg * c3_reg;
            t_reg[5] <= s1c2_reg * s3_reg;
            t_reg[6] <= s1c2_reg * c3_reg;
            t_reg[7] <= c1s2_reg * s3_reg;

            sz_reg     <= p2z_reg;
            sum_reg[0] <= SW'(t_reg[0]) + SW'(t_reg[1]);
            sum_reg[1] <= SW'(t_reg[2]) - SW'(t_reg[3]);
            sum_reg[2] <= SW'(t_reg[4]) + SW'(t_reg[5]);
            sum_reg[3] <= SW'(t_reg[6]) - SW'(t_reg[7]);

            if (sz_reg) begin
                o_reg.quat_w <= {1'b0, {(OUT_W-1){1'b1}}};
                o_reg.quat_x <= '0;
                o_reg.quat_y <= '0;
                o_reg.quat_z <= '0;
            end else begin
                o_reg.quat_w <= to_out(sum_reg[0]);
                o_reg.quat_x <= to_out(sum_reg[1]);
                o_reg.quat_y <= to_out(sum_reg[2]);
                o_reg.quat_z <= to_out(sum_reg[3]);
            end
        end
    end

endmodule
